FILE: rtl/sle_pkg.sv
// Shared types and codes for the sorted list engine.
package sle_pkg;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_DEL_KEY = 2'd1;
    localparam logic [1:0] REQ_DEL_POS = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] IDX_SRC_COUNT = 2'd0;
    localparam logic [1:0] IDX_SRC_ZERO  = 2'd1;
    localparam logic [1:0] IDX_SRC_POS   = 2'd2;

    localparam logic [1:0] RD_PREV = 2'd0;
    localparam logic [1:0] RD_CUR  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    localparam logic WR_KEY  = 1'b0;
    localparam logic WR_DATA = 1'b1;

    typedef struct packed {
        logic       req_load;
        logic       idx_load;
        logic [1:0] idx_src;
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_en;
        logic [1:0] rd_src;
        logic       wr_en;
        logic       wr_src;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_miss;
        logic idx_zero;
        logic idx_at_end;
        logic idx_last;
        logic key_less;
        logic key_equal;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/sle_ram.sv
// Generic simple dual-port RAM with registered read data.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sle_ctrl.sv
// Request sequencer: walks the sorted store one entry at a time.
module sle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_req_type,
    output logic          o_ready,
    input  sle_pkg::t_sts i_sts,
    output sle_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DK_RD   = 3'd3;
    localparam logic [2:0] S_DK_CMP  = 3'd4;
    localparam logic [2:0] S_SH_RD   = 3'd5;
    localparam logic [2:0] S_SH_WR   = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_status;
    logic [1:0] n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= sle_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.req_load = 1'b1;
                    case (i_req_type)
                        sle_pkg::REQ_INSERT: begin
                            if (i_sts.full) begin
                                n_status = sle_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                o_cmd.idx_load = 1'b1;
                                o_cmd.idx_src  = sle_pkg::IDX_SRC_COUNT;
                                n_state        = S_INS_RD;
                            end
                        end
                        sle_pkg::REQ_DEL_KEY: begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_src  = sle_pkg::IDX_SRC_ZERO;
                            n_state        = S_DK_RD;
                        end
                        sle_pkg::REQ_DEL_POS: begin
                            if (i_sts.pos_miss) begin
                                n_status = sle_pkg::ST_MISS;
                                n_state  = S_RESP;
                            end else begin
                                o_cmd.idx_load = 1'b1;
                                o_cmd.idx_src  = sle_pkg::IDX_SRC_POS;
                                n_state        = S_SH_RD;
                            end
                        end
                        default: begin
                            n_status = sle_pkg::ST_MISS;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_src  = sle_pkg::WR_KEY;
                    o_cmd.cnt_inc = 1'b1;
                    n_status      = sle_pkg::ST_DONE;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = sle_pkg::RD_PREV;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.key_less) begin
                    o_cmd.wr_src  = sle_pkg::WR_DATA;
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    o_cmd.wr_src  = sle_pkg::WR_KEY;
                    o_cmd.cnt_inc = 1'b1;
                    n_status      = sle_pkg::ST_DONE;
                    n_state       = S_RESP;
                end
            end
            S_DK_RD: begin
                if (i_sts.idx_at_end) begin
                    n_status = sle_pkg::ST_MISS;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = sle_pkg::RD_CUR;
                    n_state      = S_DK_CMP;
                end
            end
            S_DK_CMP: begin
                if (i_sts.key_equal) begin
                    n_state = S_SH_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_DK_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_status      = sle_pkg::ST_DONE;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = sle_pkg::RD_NEXT;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = sle_pkg::WR_DATA;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_SH_RD;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sle_dpath.sv
// Key store, walk index, entry count and result register.
module sle_dpath #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_key_value,
    input  logic [5:0]    i_position,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic [6:0]    o_entry_count,
    input  sle_pkg::t_cmd i_cmd,
    output sle_pkg::t_sts o_sts
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = CNT_W + 6;

    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    n_idx;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [6:0]          r_out_count;
    logic [CNT_W-1:0]    rd_idx;
    logic [KEY_BITS-1:0] rd_data;
    logic [KEY_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_key <= KEY_BITS'(i_key_value);
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_load) begin
            case (i_cmd.idx_src)
                sle_pkg::IDX_SRC_COUNT: n_idx = r_count;
                sle_pkg::IDX_SRC_ZERO:  n_idx = '0;
                sle_pkg::IDX_SRC_POS:   n_idx = CNT_W'(i_position);
                default:                n_idx = '0;
            endcase
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CNT_W'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - CNT_W'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_count  <= 7'(r_count);
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            sle_pkg::RD_PREV: rd_idx = r_idx - CNT_W'(1);
            sle_pkg::RD_CUR:  rd_idx = r_idx;
            sle_pkg::RD_NEXT: rd_idx = r_idx + CNT_W'(1);
            default:          rd_idx = r_idx;
        endcase
    end

    assign wr_data = (i_cmd.wr_src == sle_pkg::WR_DATA) ? rd_data : r_key;

    sle_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(r_idx[IDX_W-1:0]),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(rd_idx[IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    assign o_sts.full       = (r_count >= CNT_W'(CAPACITY));
    assign o_sts.pos_miss   = (CMP_W'(i_position) >= CMP_W'(r_count));
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.idx_at_end = (r_idx == r_count);
    assign o_sts.idx_last   = ((r_idx + CNT_W'(1)) == r_count);
    assign o_sts.key_less   = (rd_data < r_key);
    assign o_sts.key_equal  = (rd_data == r_key);
    assign o_sts.out_free   = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

FILE: rtl/sorted_list_engine.sv
// Top level: sorted list priority queue, keys held in descending order.
// One request in flight; each entry visited is first read, then compared or written, since
// the key store has a single registered read port. Result register frees input side.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
module sorted_list_engine #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_key_value,
    input  logic [5:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count
);

    sle_pkg::t_cmd cmd;
    sle_pkg::t_sts sts;

    sle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req_type(i_req_type),
        .o_ready   (o_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    sle_dpath #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_value  (i_key_value),
        .i_position   (i_position),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_entry_count(o_entry_count),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

FILE: rtl/sle_chk.sv
// Port-level checker for the sorted list engine, bound to the top level.
module sle_chk #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [6:0]  o_entry_count
);

    localparam logic [6:0] CAP_MOD = 7'(CAPACITY % 128);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == sle_pkg::ST_DONE || o_status == sle_pkg::ST_MISS ||
                     o_status == sle_pkg::ST_FULL))
        else $error("illegal status code");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sle_pkg::ST_FULL) |-> (o_entry_count == CAP_MOD))
        else $error("full reject without full count");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_entry_count)))
        else $error("result changed while stalled");

endmodule

bind sorted_list_engine sle_chk #(.CAPACITY(CAPACITY)) u_sle_chk (.*);
